[rtl/grpa_pkg.sv]
// Shared types and constants of the grid rectangle placement allocator.
// Depends on nothing; every other file imports it.
package grpa_pkg;

    localparam int MAX_SIDE_DEF = 50;
    localparam int ID_BITS_DEF  = 16;
    localparam int SIDE_W       = 6;
    localparam int SLOT_W       = 12;
    localparam int OUT_ID_W     = 16;

    // Operation codes carried by one input beat.
    typedef enum logic [2:0] {
        OP_FIT    = 3'd0,
        OP_PLACE  = 3'd1,
        OP_REMOVE = 3'd2,
        OP_MOVE   = 3'd3,
        OP_FIND   = 3'd4,
        OP_QUERY  = 3'd5,
        OP_COUNT  = 3'd6,
        OP_CLEAR  = 3'd7
    } t_op;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_BOUND,
        S_FRD,
        S_FCHK,
        S_PUT,
        S_DRD,
        S_DCHK,
        S_QRD,
        S_QCHK
    } t_state;

    // Request to the slot divider.
    typedef struct packed {
        logic              start;
        logic [SLOT_W-1:0] dividend;
        logic [SIDE_W-1:0] divisor;
    } t_div_req;

    // Answer of the slot divider.
    typedef struct packed {
        logic              done;
        logic [SIDE_W-1:0] quot;
        logic [SIDE_W-1:0] rem;
    } t_div_res;

endpackage

[rtl/grpa_cell_mem.sv]
// Cell store of the allocator: one write port and one registered read port.
// Depends on grpa_pkg.
module grpa_cell_mem
    import grpa_pkg::*;
#(
    parameter int DEPTH = MAX_SIDE_DEF * MAX_SIDE_DEF,
    parameter int WIDTH = ID_BITS_DEF + 2 * SIDE_W + 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/grpa_divmod.sv]
// Iterative slot divider: splits a slot into row and column by repeated
// subtraction of the grid width. Depends on grpa_pkg.
module grpa_divmod
    import grpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_res o_res
);

    logic              r_busy;
    logic [SLOT_W-1:0] r_rem;
    logic [SIDE_W-1:0] r_quot;
    logic [SIDE_W-1:0] r_div;
    logic              w_done;

    assign w_done       = r_busy && (r_rem < SLOT_W'(r_div));
    assign o_res.done   = w_done;
    assign o_res.quot   = r_quot;
    assign o_res.rem    = r_rem[SIDE_W-1:0];

    // One subtraction per cycle until the remainder drops below the divisor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
        if (i_req.start) begin
            r_rem  <= i_req.dividend;
            r_quot <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy && !w_done) begin
            r_rem  <= r_rem - SLOT_W'(r_div);
            r_quot <= r_quot + 1'b1;
        end
    end

endmodule

[rtl/grid_rect_placement_allocator.sv]
// Count reads the free register; query splits the slot into row and column and reads it;
// fit splits, checks bounds and reads each rectangle cell; place then writes each cell;
// remove reads every grid cell; move is fit, remove and place; find tries each position
// of each orientation. One beat at a time: the input stalls while a beat is in work or
// its result waits. Reset, a register write and, once configured, a clear beat each sweep
// all MAX_SIDE*MAX_SIDE cells, one per cycle, and no input beat is taken meanwhile.
module grid_rect_placement_allocator
    import grpa_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF,
    parameter int ID_BITS  = ID_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [SIDE_W-1:0]   i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_op,
    input  logic [OUT_ID_W-1:0] i_item_id,
    input  logic [SIDE_W-1:0]   i_size_w,
    input  logic [SIDE_W-1:0]   i_size_h,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic                i_rotated,
    input  logic                i_allow_rotation,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_ok,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic                o_rotated_out,
    output logic [OUT_ID_W-1:0] o_owner_id,
    output logic                o_occupied,
    output logic [SLOT_W-1:0]   o_free_count
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = ID_BITS + 2 * SIDE_W + 1;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [ID_BITS-1:0]  r_id, n_id, r_ign, n_ign;
    logic [SLOT_W-1:0]   r_slot, n_slot, r_cur, n_cur, r_scan, n_scan;
    logic [SIDE_W-1:0]   r_sw, n_sw, r_sh, n_sh, r_fw, n_fw, r_fh, n_fh;
    logic                r_allow, n_allow, r_pass, n_pass, r_any, n_any;
    logic [SIDE_W-1:0]   r_x0, n_x0, r_y0, n_y0, r_wx, n_wx, r_wy, n_wy;
    logic [SLOT_W-1:0]   r_addr, n_addr, r_row, n_row, r_clr, n_clr;
    logic                r_clr_reply, n_clr_reply;
    logic [SIDE_W-1:0]   r_gw, n_gw, r_gh, n_gh;
    logic                r_ready, n_ready;
    logic [SLOT_W-1:0]   r_free, n_free;
    logic                r_out_valid, n_out_valid;
    logic                r_ok, n_ok, r_rot, n_rot, r_occ, n_occ;
    logic [SLOT_W-1:0]   r_slot_out, n_slot_out, r_free_out, n_free_out;
    logic [OUT_ID_W-1:0] r_owner, n_owner;

    logic                w_in_acc, w_cfg_acc;
    logic [SLOT_W-1:0]   w_area, w_n;
    logic [ID_BITS-1:0]  w_item_id;
    logic [SIDE_W-1:0]   w_cfg_val;
    t_div_req            w_div_req;
    t_div_res            w_div_res;
    logic                w_we;
    logic [SLOT_W-1:0]   w_waddr, w_raddr;
    logic [CW-1:0]       w_wdata, w_rd;
    logic [ID_BITS-1:0]  w_rd_id;
    logic                w_rd_anchor;
    logic [SIDE_W-1:0]   w_rd_ox, w_rd_oy, w_dx, w_dy;
    logic [SLOT_W-1:0]   w_qprod;
    logic                w_last;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_area      = SLOT_W'(r_gw * r_gh);
    assign w_n         = r_ready ? w_area : '0;
    assign w_item_id   = ID_BITS'(i_item_id);

    // Fields of the cell that was read last cycle.
    assign w_rd_id     = w_rd[CW-1:2*SIDE_W+1];
    assign w_rd_anchor = w_rd[2*SIDE_W];
    assign w_rd_ox     = w_rd[2*SIDE_W-1:SIDE_W];
    assign w_rd_oy     = w_rd[SIDE_W-1:0];
    assign w_dx        = r_x0 - w_rd_ox;
    assign w_dy        = r_y0 - w_rd_oy;
    assign w_qprod     = SLOT_W'(w_dy * r_gw);

    // Last cell of the rectangle walk.
    assign w_last = (r_wx + 1'b1 == r_fw) && (r_wy + 1'b1 == r_fh);

    // Register write value, clamped to one up to the largest side.
    always_comb begin
        w_cfg_val = i_cfg_data;
        if (w_cfg_val == '0) begin
            w_cfg_val = SIDE_W'(1);
        end
        if ((SIDE_W + 1)'(w_cfg_val) > (SIDE_W + 1)'(MAX_SIDE)) begin
            w_cfg_val = SIDE_W'(MAX_SIDE);
        end
    end

    grpa_divmod u_divmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_res   (w_div_res)
    );

    grpa_cell_mem #(
        .DEPTH (CELLS),
        .WIDTH (CW)
    ) u_cell_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_rd)
    );

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_clr_reply <= 1'b0;
            r_gw        <= SIDE_W'(1);
            r_gh        <= SIDE_W'(1);
            r_ready     <= 1'b0;
            r_free      <= SLOT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_clr_reply <= n_clr_reply;
            r_gw        <= n_gw;
            r_gh        <= n_gh;
            r_ready     <= n_ready;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_id       <= n_id;
        r_ign      <= n_ign;
        r_slot     <= n_slot;
        r_cur      <= n_cur;
        r_scan     <= n_scan;
        r_sw       <= n_sw;
        r_sh       <= n_sh;
        r_fw       <= n_fw;
        r_fh       <= n_fh;
        r_allow    <= n_allow;
        r_pass     <= n_pass;
        r_any      <= n_any;
        r_x0       <= n_x0;
        r_y0       <= n_y0;
        r_wx       <= n_wx;
        r_wy       <= n_wy;
        r_addr     <= n_addr;
        r_row      <= n_row;
        r_ok       <= n_ok;
        r_rot      <= n_rot;
        r_occ      <= n_occ;
        r_slot_out <= n_slot_out;
        r_free_out <= n_free_out;
        r_owner    <= n_owner;
    end

    // Sequencer: next state, memory port control and the result beat.
    always_comb begin
        logic                fin, fin_ok, fin_rot, fin_occ;
        logic [SLOT_W-1:0]   fin_slot;
        logic [OUT_ID_W-1:0] fin_owner;
        logic                fit_pass, fit_fail, drop_end, put_go;

        fin       = 1'b0;
        fin_ok    = 1'b0;
        fin_rot   = 1'b0;
        fin_occ   = 1'b0;
        fin_slot  = '0;
        fin_owner = '0;
        fit_pass  = 1'b0;
        fit_fail  = 1'b0;
        drop_end  = 1'b0;
        put_go    = 1'b0;

        n_state     = r_state;
        n_op        = r_op;
        n_id        = r_id;
        n_ign       = r_ign;
        n_slot      = r_slot;
        n_cur       = r_cur;
        n_scan      = r_scan;
        n_sw        = r_sw;
        n_sh        = r_sh;
        n_fw        = r_fw;
        n_fh        = r_fh;
        n_allow     = r_allow;
        n_pass      = r_pass;
        n_any       = r_any;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_wx        = r_wx;
        n_wy        = r_wy;
        n_addr      = r_addr;
        n_row       = r_row;
        n_clr       = r_clr;
        n_clr_reply = r_clr_reply;
        n_gw        = r_gw;
        n_gh        = r_gh;
        n_ready     = r_ready;
        n_free      = r_free;
        n_out_valid = r_out_valid && i_out_stall;
        n_ok        = r_ok;
        n_rot       = r_rot;
        n_occ       = r_occ;
        n_slot_out  = r_slot_out;
        n_free_out  = r_free_out;
        n_owner     = r_owner;

        w_div_req.start    = 1'b0;
        w_div_req.dividend = i_slot;
        w_div_req.divisor  = r_gw;
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = '0;
        w_raddr = r_addr;

        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == SLOT_W'(CELLS - 1)) begin
                    n_free  = w_area;
                    n_state = S_IDLE;
                    if (r_clr_reply) begin
                        fin    = 1'b1;
                        fin_ok = 1'b1;
                    end
                end
            end

            S_IDLE: begin
                if (w_in_acc) begin
                    n_op    = t_op'(i_op);
                    n_id    = w_item_id;
                    n_slot  = i_slot;
                    n_cur   = i_slot;
                    n_sw    = i_size_w;
                    n_sh    = i_size_h;
                    n_allow = i_allow_rotation;
                    n_fw    = i_rotated ? i_size_h : i_size_w;
                    n_fh    = i_rotated ? i_size_w : i_size_h;
                    n_ign   = '0;
                    n_pass  = 1'b0;
                    n_scan  = '0;
                    n_any   = 1'b0;
                    unique case (t_op'(i_op))
                        OP_FIT, OP_PLACE, OP_MOVE, OP_QUERY: begin
                            if (t_op'(i_op) == OP_FIT || t_op'(i_op) == OP_MOVE) begin
                                n_ign = w_item_id;
                            end
                            if (i_slot >= w_n) begin
                                fin = 1'b1;
                            end else if (w_item_id == '0 &&
                                         (t_op'(i_op) == OP_PLACE ||
                                          t_op'(i_op) == OP_MOVE)) begin
                                fin = 1'b1;
                            end else begin
                                w_div_req.start = 1'b1;
                                n_state         = S_DIV;
                            end
                        end
                        OP_REMOVE: begin
                            if (w_item_id == '0) begin
                                fin = 1'b1;
                            end else begin
                                n_state = S_DRD;
                            end
                        end
                        OP_FIND: begin
                            n_fw  = i_size_w;
                            n_fh  = i_size_h;
                            n_cur = '0;
                            n_x0  = '0;
                            n_y0  = '0;
                            if (w_n == '0) begin
                                fin = 1'b1;
                            end else begin
                                n_state = S_BOUND;
                            end
                        end
                        OP_COUNT: begin
                            fin    = 1'b1;
                            fin_ok = 1'b1;
                        end
                        OP_CLEAR: begin
                            if (r_ready) begin
                                n_clr       = '0;
                                n_clr_reply = 1'b1;
                                n_state     = S_CLEAR;
                            end else begin
                                fin    = 1'b1;
                                fin_ok = 1'b1;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_DIV: begin
                if (w_div_res.done) begin
                    n_x0    = w_div_res.rem;
                    n_y0    = w_div_res.quot;
                    n_state = (r_op == OP_QUERY) ? S_QRD : S_BOUND;
                end
            end

            S_BOUND: begin
                if ((SIDE_W + 1)'(r_x0) + (SIDE_W + 1)'(r_fw) > (SIDE_W + 1)'(r_gw) ||
                    (SIDE_W + 1)'(r_y0) + (SIDE_W + 1)'(r_fh) > (SIDE_W + 1)'(r_gh)) begin
                    fit_fail = 1'b1;
                end else if (r_fw == '0 || r_fh == '0) begin
                    fit_pass = 1'b1;
                end else begin
                    n_wx    = '0;
                    n_wy    = '0;
                    n_addr  = r_cur;
                    n_row   = r_cur;
                    n_state = S_FRD;
                end
            end

            S_FRD: begin
                w_raddr = r_addr;
                n_state = S_FCHK;
            end

            S_FCHK: begin
                if (w_rd_id != '0 && !(r_ign != '0 && w_rd_id == r_ign)) begin
                    fit_fail = 1'b1;
                end else if (w_last) begin
                    fit_pass = 1'b1;
                end else begin
                    n_state = S_FRD;
                    if (r_wx + 1'b1 != r_fw) begin
                        n_wx   = r_wx + 1'b1;
                        n_addr = r_addr + 1'b1;
                    end else begin
                        n_wx   = '0;
                        n_wy   = r_wy + 1'b1;
                        n_row  = r_row + SLOT_W'(r_gw);
                        n_addr = r_row + SLOT_W'(r_gw);
                    end
                end
            end

            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = {r_id, (r_wx == '0 && r_wy == '0), r_wx, r_wy};
                if (r_free != '0) begin
                    n_free = r_free - 1'b1;
                end
                if (w_last) begin
                    fin    = 1'b1;
                    fin_ok = 1'b1;
                end else if (r_wx + 1'b1 != r_fw) begin
                    n_wx   = r_wx + 1'b1;
                    n_addr = r_addr + 1'b1;
                end else begin
                    n_wx   = '0;
                    n_wy   = r_wy + 1'b1;
                    n_row  = r_row + SLOT_W'(r_gw);
                    n_addr = r_row + SLOT_W'(r_gw);
                end
            end

            S_DRD: begin
                w_raddr = r_scan;
                if (r_scan == w_n) begin
                    drop_end = 1'b1;
                end else begin
                    n_state = S_DCHK;
                end
            end

            S_DCHK: begin
                if (w_rd_id == r_id) begin
                    w_we    = 1'b1;
                    w_waddr = r_scan;
                    n_free  = r_free + 1'b1;
                    n_any   = 1'b1;
                end
                n_scan  = r_scan + 1'b1;
                n_state = S_DRD;
            end

            S_QRD: begin
                w_raddr = r_slot;
                n_state = S_QCHK;
            end

            S_QCHK: begin
                fin       = 1'b1;
                fin_ok    = 1'b1;
                fin_owner = OUT_ID_W'(w_rd_id);
                fin_occ   = (w_rd_id != '0);
                if (w_rd_id != '0) begin
                    if (w_rd_anchor) begin
                        fin_slot = r_slot;
                    end else if (w_rd_ox <= r_x0 && w_rd_oy <= r_y0) begin
                        fin_slot = w_qprod + SLOT_W'(w_dx);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Outcome of one fit test.
        if (fit_pass) begin
            case (r_op)
                OP_PLACE: put_go = 1'b1;
                OP_MOVE: begin
                    n_scan  = '0;
                    n_any   = 1'b0;
                    n_state = S_DRD;
                end
                OP_FIND: begin
                    fin      = 1'b1;
                    fin_ok   = 1'b1;
                    fin_slot = r_cur;
                    fin_rot  = r_pass;
                end
                default: begin
                    fin    = 1'b1;
                    fin_ok = 1'b1;
                end
            endcase
        end
        if (fit_fail) begin
            if (r_op == OP_FIND) begin
                n_state = S_BOUND;
                if (r_cur + 1'b1 == w_n) begin
                    n_cur = '0;
                    n_x0  = '0;
                    n_y0  = '0;
                    if (!r_pass && r_allow && r_sw != r_sh) begin
                        n_pass = 1'b1;
                        n_fw   = r_sh;
                        n_fh   = r_sw;
                    end else begin
                        fin = 1'b1;
                    end
                end else begin
                    n_cur = r_cur + 1'b1;
                    if (r_x0 + 1'b1 == r_gw) begin
                        n_x0 = '0;
                        n_y0 = r_y0 + 1'b1;
                    end else begin
                        n_x0 = r_x0 + 1'b1;
                    end
                end
            end else begin
                fin = 1'b1;
            end
        end

        // End of an owner sweep.
        if (drop_end) begin
            if (r_op == OP_MOVE) begin
                put_go = 1'b1;
            end else begin
                fin    = 1'b1;
                fin_ok = r_any;
            end
        end

        // Start writing the rectangle at the target slot.
        if (put_go) begin
            if (r_fw == '0 || r_fh == '0) begin
                fin    = 1'b1;
                fin_ok = 1'b1;
            end else begin
                n_wx    = '0;
                n_wy    = '0;
                n_addr  = r_slot;
                n_row   = r_slot;
                n_state = S_PUT;
            end
        end

        // Load the result beat.
        if (fin) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_ok        = fin_ok;
            n_rot       = fin_rot;
            n_occ       = fin_occ;
            n_slot_out  = fin_slot;
            n_owner     = fin_owner;
            n_free_out  = r_ready ? n_free : '0;
        end

        // Register write: resize the grid and sweep the store.
        if (w_cfg_acc) begin
            if (i_cfg_index) begin
                n_gh = w_cfg_val;
            end else begin
                n_gw = w_cfg_val;
            end
            n_ready     = 1'b1;
            n_clr       = '0;
            n_clr_reply = 1'b0;
            n_state     = S_CLEAR;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_slot_out    = r_slot_out;
    assign o_rotated_out = r_rot;
    assign o_owner_id    = r_owner;
    assign o_occupied    = r_occ;
    assign o_free_count  = r_free_out;

    // The free count never exceeds the grid area between beats.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_ready) |-> (r_free <= w_area))
        else $error("free cell count above grid area");

    // An accepted beat either starts work or posts its result.
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE || r_out_valid))
        else $error("accepted beat left no trace");

    // The store is never written while the block waits for a beat.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("cell store written while idle");

    // A result beat is only produced while the input side is stalled.
    a_out_stalls_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_in_stall)
        else $error("input taken while a result waits");

endmodule

[sim/grid_rect_placement_allocator_test.sv]
// Self-checking testbench of the grid rectangle placement allocator.
// Depends on grpa_pkg and grid_rect_placement_allocator; keeps its own grid model.
`timescale 1ns / 1ps

module grid_rect_placement_allocator_test;
    import grpa_pkg::*;

    localparam int CELL_NUM   = MAX_SIDE_DEF * MAX_SIDE_DEF;
    localparam int IDLE_LIMIT = 400000;

    // Configuration register indexes.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct {
        logic              ok;
        logic [SLOT_W-1:0] slot_out;
        logic              rot;
        logic [15:0]       owner;
        logic              occ;
        logic [SLOT_W-1:0] free;
    } t_answer;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [SIDE_W-1:0]   i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [2:0]          i_op;
    logic [OUT_ID_W-1:0] i_item_id;
    logic [SIDE_W-1:0]   i_size_w;
    logic [SIDE_W-1:0]   i_size_h;
    logic [SLOT_W-1:0]   i_slot;
    logic                i_rotated;
    logic                i_allow_rotation;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_ok;
    logic [SLOT_W-1:0]   o_slot_out;
    logic                o_rotated_out;
    logic [OUT_ID_W-1:0] o_owner_id;
    logic                o_occupied;
    logic [SLOT_W-1:0]   o_free_count;

    grid_rect_placement_allocator u_dut (.*);

    // Grid model state.
    logic [15:0] grid_owner [CELL_NUM];
    bit          grid_anchor[CELL_NUM];
    int          grid_offx  [CELL_NUM];
    int          grid_offy  [CELL_NUM];
    int          cols, rows, cells_free;
    bit          grid_on;

    t_answer answers_due[$];
    int      mismatches;
    int      results_seen;
    int      idle_on;
    int      rx_wait;
    int      rx_hold;
    int      quiet_cycles;

    // Clock.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int slots_in_use();
        return grid_on ? cols * rows : 0;
    endfunction

    function automatic void wipe_grid();
        for (int i = 0; i < CELL_NUM; i++) begin
            grid_owner[i]  = '0;
            grid_anchor[i] = 0;
            grid_offx[i]   = 0;
            grid_offy[i]   = 0;
        end
        cells_free = cols * rows;
    endfunction

    function automatic bit rect_fits(int w, int h, int slot, logic [15:0] skip_id);
        int x0;
        int y0;
        logic [15:0] who;
        if (slot >= slots_in_use()) return 0;
        x0 = slot % cols;
        y0 = slot / cols;
        if (x0 + w > cols || y0 + h > rows) return 0;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                who = grid_owner[(y0 + y) * cols + x0 + x];
                if (who != 0 && !(skip_id != 0 && who == skip_id)) return 0;
            end
        end
        return 1;
    endfunction

    function automatic void rect_put(logic [15:0] id, int w, int h, int slot);
        int x0;
        int y0;
        int c;
        x0 = slot % cols;
        y0 = slot / cols;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                c = (y0 + y) * cols + x0 + x;
                if (grid_owner[c] == 0 && cells_free > 0) cells_free--;
                grid_owner[c]  = id;
                grid_anchor[c] = (x == 0 && y == 0);
                grid_offx[c]   = x;
                grid_offy[c]   = y;
            end
        end
    endfunction

    function automatic bit owner_drop(logic [15:0] id);
        bit any;
        any = 0;
        for (int i = 0; i < slots_in_use(); i++) begin
            if (grid_owner[i] == id) begin
                grid_owner[i]  = '0;
                grid_anchor[i] = 0;
                grid_offx[i]   = 0;
                grid_offy[i]   = 0;
                cells_free++;
                any = 1;
            end
        end
        return any;
    endfunction

    function automatic void grid_config(logic idx, logic [SIDE_W-1:0] data);
        int v;
        v = (data < 1) ? 1 : (data > MAX_SIDE_DEF) ? MAX_SIDE_DEF : data;
        if (idx == REG_WIDTH) cols = v;
        else rows = v;
        grid_on = 1;
        wipe_grid();
    endfunction

    // Applies one beat to the grid model and returns the answer it must give.
    function automatic t_answer grid_apply(t_op op, logic [15:0] id, int sw, int sh,
                                           int slot, bit rot, bit allow);
        t_answer a;
        int ew;
        int eh;
        int n;
        int x;
        int y;
        ew = rot ? sh : sw;
        eh = rot ? sw : sh;
        n  = slots_in_use();
        a  = '{default: '0};
        case (op)
            OP_FIT: a.ok = rect_fits(ew, eh, slot, id);
            OP_PLACE: begin
                if (id != 0 && rect_fits(ew, eh, slot, '0)) begin
                    rect_put(id, ew, eh, slot);
                    a.ok = 1;
                end
            end
            OP_REMOVE: if (id != 0) a.ok = owner_drop(id);
            OP_MOVE: begin
                if (id != 0 && rect_fits(ew, eh, slot, id)) begin
                    void'(owner_drop(id));
                    rect_put(id, ew, eh, slot);
                    a.ok = 1;
                end
            end
            OP_FIND: begin
                for (int i = 0; i < n && !a.ok; i++) begin
                    if (rect_fits(sw, sh, i, '0)) begin
                        a.ok = 1;
                        a.slot_out = SLOT_W'(i);
                    end
                end
                if (!a.ok && allow && sw != sh) begin
                    for (int i = 0; i < n && !a.ok; i++) begin
                        if (rect_fits(sh, sw, i, '0)) begin
                            a.ok = 1;
                            a.slot_out = SLOT_W'(i);
                            a.rot = 1;
                        end
                    end
                end
            end
            OP_QUERY: begin
                if (slot < n) begin
                    a.ok    = 1;
                    a.owner = grid_owner[slot];
                    a.occ   = grid_owner[slot] != 0;
                    if (a.occ) begin
                        x = slot % cols;
                        y = slot / cols;
                        if (grid_anchor[slot]) a.slot_out = SLOT_W'(slot);
                        else if (grid_offx[slot] <= x && grid_offy[slot] <= y)
                            a.slot_out = SLOT_W'((y - grid_offy[slot]) * cols
                                                 + (x - grid_offx[slot]));
                    end
                end
            end
            OP_COUNT: a.ok = 1;
            default: begin
                if (grid_on) wipe_grid();
                a.ok = 1;
            end
        endcase
        a.free = grid_on ? SLOT_W'(cells_free) : '0;
        return a;
    endfunction

    // Sends one beat; the model is updated when the beat is taken.
    task automatic send_beat(t_op op, logic [15:0] id, int sw, int sh, int slot,
                             bit rot, bit allow);
        int gap;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_op             <= op;
        i_item_id        <= id;
        i_size_w         <= sw[SIDE_W-1:0];
        i_size_h         <= sh[SIDE_W-1:0];
        i_slot           <= slot[SLOT_W-1:0];
        i_rotated        <= rot;
        i_allow_rotation <= allow;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        answers_due.push_back(grid_apply(op, id, sw & 63, sh & 63, slot & 4095, rot, allow));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (answers_due.size() == 0);
        repeat (20) @(negedge i_clk);
    endtask

    // Register writes wait until every pending result has come back.
    task automatic write_reg(logic idx, logic [SIDE_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        grid_config(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(int w, int h);
        write_reg(REG_WIDTH, w[SIDE_W-1:0]);
        write_reg(REG_HEIGHT, h[SIDE_W-1:0]);
    endtask

    // Before any register write no slot exists.
    task automatic test_unconfigured();
        send_beat(OP_FIT, 16'd0, 0, 0, 0, 0, 0);
        send_beat(OP_PLACE, 16'd1, 1, 1, 0, 0, 0);
        send_beat(OP_REMOVE, 16'd1, 0, 0, 0, 0, 0);
        send_beat(OP_MOVE, 16'd1, 1, 1, 0, 0, 0);
        send_beat(OP_FIND, 16'd0, 0, 0, 0, 0, 1);
        send_beat(OP_QUERY, 16'd0, 0, 0, 0, 0, 0);
        send_beat(OP_COUNT, 16'd0, 0, 0, 0, 0, 0);
        send_beat(OP_CLEAR, 16'd0, 0, 0, 0, 0, 0);
    endtask

    // Clamped register values and the largest grid.
    task automatic test_extremes();
        write_reg(REG_WIDTH, 6'd0);
        write_reg(REG_HEIGHT, 6'd63);
        send_beat(OP_PLACE, 16'hFFFF, 1, 50, 0, 0, 0);
        send_beat(OP_QUERY, 16'd0, 0, 0, 49, 0, 0);
        write_reg(REG_WIDTH, 6'd63);
        send_beat(OP_PLACE, 16'hFFFF, 50, 50, 0, 0, 0);
        send_beat(OP_QUERY, 16'd0, 0, 0, 2499, 0, 0);
        send_beat(OP_FIT, 16'hFFFF, 50, 50, 0, 0, 0);
        send_beat(OP_FIT, 16'd0, 63, 63, 0, 1, 0);
        send_beat(OP_QUERY, 16'd0, 0, 0, 4095, 1, 1);
        send_beat(OP_REMOVE, 16'hFFFF, 0, 0, 0, 0, 0);
        send_beat(OP_FIND, 16'd0, 0, 3, 2499, 0, 1);
        send_beat(OP_CLEAR, 16'd0, 0, 0, 0, 0, 0);
    endtask

    // Ownership, rotation, move, zero ID and the search orders on a small grid.
    task automatic test_placement();
        set_grid(6, 4);
        send_beat(OP_PLACE, 16'd0, 2, 2, 0, 0, 0);
        send_beat(OP_PLACE, 16'd7, 2, 3, 1, 1, 0);
        send_beat(OP_QUERY, 16'd0, 0, 0, 9, 0, 0);
        send_beat(OP_FIT, 16'd7, 3, 2, 1, 0, 0);
        send_beat(OP_FIT, 16'd0, 3, 2, 1, 0, 0);
        send_beat(OP_MOVE, 16'd7, 2, 2, 16, 0, 0);
        send_beat(OP_MOVE, 16'd0, 1, 1, 0, 0, 0);
        send_beat(OP_PLACE, 16'd9, 0, 4, 5, 0, 0);
        send_beat(OP_FIND, 16'd0, 5, 2, 0, 0, 0);
        send_beat(OP_FIND, 16'd0, 1, 5, 0, 0, 1);
        send_beat(OP_FIND, 16'd0, 3, 3, 0, 0, 1);
        send_beat(OP_REMOVE, 16'd0, 0, 0, 0, 0, 0);
        send_beat(OP_REMOVE, 16'd3, 0, 0, 0, 0, 0);
        send_beat(OP_COUNT, 16'd0, 0, 0, 0, 0, 0);
    endtask

    // Random beats of all eight operations, mostly among a few owners.
    task automatic test_random(int w, int h, int beats, int max_side);
        t_op op;
        logic [15:0] id;
        int n;
        set_grid(w, h);
        n = w * h;
        for (int k = 0; k < beats; k++) begin
            if (k % 40 == 0) idle_on = $urandom_range(0, 1);
            op = t_op'($urandom_range(0, 15) < 12 ? $urandom_range(0, 6)
                                                  : $urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0: id = '0;
                1: id = 16'($urandom_range(0, 65535));
                default: id = 16'($urandom_range(1, 5));
            endcase
            send_beat(op, id,
                      $urandom_range(0, 15) == 0 ? 63 : $urandom_range(0, max_side),
                      $urandom_range(0, 15) == 0 ? 63 : $urandom_range(0, max_side),
                      $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
                                                : $urandom_range(0, n - 1),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // The receiver holds off long enough for the input to back up.
    task automatic test_backpressure();
        set_grid(4, 4);
        @(posedge i_clk);
        rx_hold = 300;
        for (int k = 0; k < 6; k++)
            send_beat(t_op'($urandom_range(0, 6)), 16'd2, 1, 2, k, 0, 1);
    endtask

    // Receiver stall.
    initial begin
        i_out_stall = 1'b1;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_out_stall <= 1'b1;
                rx_hold--;
            end else if (rx_wait > 0) begin
                i_out_stall <= 1'b1;
                rx_wait--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Result check against the oldest pending answer.
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
            end else begin
                e = answers_due.pop_front();
                if (o_ok !== e.ok || o_slot_out !== e.slot_out || o_rotated_out !== e.rot
                        || o_owner_id !== e.owner || o_occupied !== e.occ
                        || o_free_count !== e.free) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at %0t: exp ok=%0d slot=%0d rot=%0d owner=%h ",
                                  "occ=%0d free=%0d, got ok=%0d slot=%0d rot=%0d owner=%h ",
                                  "occ=%0d free=%0d"}, $realtime, e.ok, e.slot_out, e.rot,
                                 e.owner, e.occ, e.free, o_ok, o_slot_out, o_rotated_out,
                                 o_owner_id, o_occupied, o_free_count);
                end
            end
            rx_wait = idle_on ? $urandom_range(0, 18) : 0;
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("grid_rect_placement_allocator_test: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = 1'b0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_op             = '0;
        i_item_id        = '0;
        i_size_w         = '0;
        i_size_h         = '0;
        i_slot           = '0;
        i_rotated        = 1'b0;
        i_allow_rotation = 1'b0;
        mismatches       = 0;
        results_seen     = 0;
        idle_on          = 1;
        rx_wait          = 0;
        rx_hold          = 0;
        quiet_cycles     = 0;
        cols             = 1;
        rows             = 1;
        grid_on          = 0;
        wipe_grid();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_unconfigured();
        test_extremes();
        test_placement();
        test_backpressure();
        test_random(7, 5, 80, 8);
        test_random(3, 9, 50, 10);
        test_random(12, 12, 50, 13);
        test_random(1, 1, 20, 2);
        test_random(50, 50, 40, 3);

        drain_results();
        $display("covered %0d result beats over unconfigured, clamped, 1x1 up to 50x50 grids",
                 results_seen);
        $display("all eight operations with random stalls and a long output hold-off");
        if (mismatches == 0)
            $display("grid_rect_placement_allocator_test: done, clean");
        else
            $display("grid_rect_placement_allocator_test: done, errors");
        $finish;
    end

endmodule
